FILE: hw/rtl/pnse_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Petri-net step engine package
// Operation codes, register indexes and the command and status bundles that
// join the step controller to the datapath.
// ----------------------------------------------------------------------------
package pnse_pkg;

  localparam logic [2:0] OP_WR_IW    = 3'd0;
  localparam logic [2:0] OP_WR_OW    = 3'd1;
  localparam logic [2:0] OP_WR_DELAY = 3'd2;
  localparam logic [2:0] OP_WR_MARK  = 3'd3;
  localparam logic [2:0] OP_STEP     = 3'd4;
  localparam logic [2:0] OP_READ     = 3'd5;

  localparam logic [1:0] CFG_MODE   = 2'd0;
  localparam logic [1:0] CFG_PLACES = 2'd1;
  localparam logic [1:0] CFG_TRANS  = 2'd2;

  localparam logic [1:0] KIND_NONE   = 2'd0;
  localparam logic [1:0] KIND_CHOICE = 2'd1;
  localparam logic [1:0] KIND_TRIM   = 2'd2;

  localparam logic RES_STEP = 1'b0;
  localparam logic RES_READ = 1'b1;

  // Operation applied to each arc during a walk over places and transitions.
  typedef enum logic [2:0] {
    ARC_DEP_DONE,
    ARC_ENABLE,
    ARC_DEMAND,
    ARC_TRIM,
    ARC_SUB,
    ARC_DEP_FIRE
  } arc_op_e;

  typedef struct packed {
    logic       idle;
    logic       accept;
    logic       step_init;
    logic       tick;
    logic       walk_clr;
    logic       arc_apply;
    arc_op_e    arc_op;
    logic       cov_clr;
    logic       cov_apply;
    logic       make_list;
    logic       pick_two;
    logic       trim_pop;
    logic       load_timers;
    logic       out_step;
    logic       out_read;
    logic [1:0] kind;
  } cmd_t;

  typedef struct packed {
    logic mode;
    logic walk_last;
    logic cov_last;
    logic covered;
    logic n_le1;
    logic n_eq2;
    logic m_gt1;
    logic out_free;
  } sts_t;

endpackage

FILE: hw/rtl/pnse_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pnse_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: hw/rtl/pnse_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step controller
// Sequences the arc walks, cover checks and trimming of one step and hands
// results to the output register.
// ----------------------------------------------------------------------------
module pnse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_tvalid_i,
  output logic              s_tready_o,
  input  logic [2:0]        op_i,
  input  pnse_pkg::sts_t    sts_i,
  output pnse_pkg::cmd_t    cmd_o
);
  import pnse_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_ARC_INIT,
    S_ARC_RD,
    S_ARC_EX,
    S_LIST,
    S_LIST_CHK,
    S_COV_INIT,
    S_COV_RUN,
    S_COV_CHK,
    S_TRIM_POP,
    S_TIMERS,
    S_OUT_STEP,
    S_OUT_READ
  } state_e;

  state_e     state_q;
  arc_op_e    arc_op_q;
  logic [1:0] kind_q;
  logic       trim_q;
  logic       accept;

  assign s_tready_o = (state_q == S_IDLE);
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    cmd_o             = '0;
    cmd_o.arc_op      = arc_op_q;
    cmd_o.kind        = kind_q;
    cmd_o.idle        = (state_q == S_IDLE);
    cmd_o.accept      = accept;
    cmd_o.step_init   = (state_q == S_START);
    cmd_o.tick        = (state_q == S_START) && sts_i.mode;
    cmd_o.walk_clr    = (state_q == S_ARC_INIT);
    cmd_o.arc_apply   = (state_q == S_ARC_EX);
    cmd_o.cov_clr     = (state_q == S_COV_INIT);
    cmd_o.cov_apply   = (state_q == S_COV_RUN);
    cmd_o.make_list   = (state_q == S_LIST);
    cmd_o.pick_two    = (state_q == S_COV_CHK) && !sts_i.covered && !trim_q && sts_i.n_eq2;
    cmd_o.trim_pop    = (state_q == S_TRIM_POP);
    cmd_o.load_timers = (state_q == S_TIMERS);
    cmd_o.out_step    = (state_q == S_OUT_STEP) && sts_i.out_free;
    cmd_o.out_read    = (state_q == S_OUT_READ) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      arc_op_q <= ARC_ENABLE;
      kind_q   <= KIND_NONE;
      trim_q   <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept && op_i == OP_STEP) begin
            state_q <= S_START;
          end else if (accept && op_i == OP_READ) begin
            state_q <= S_OUT_READ;
          end
        end
        S_START: begin
          arc_op_q <= sts_i.mode ? ARC_DEP_DONE : ARC_ENABLE;
          state_q  <= S_ARC_INIT;
        end
        S_ARC_INIT: state_q <= S_ARC_RD;
        S_ARC_RD:   state_q <= S_ARC_EX;
        S_ARC_EX: begin
          if (!sts_i.walk_last) begin
            state_q <= S_ARC_RD;
          end else begin
            unique case (arc_op_q)
              ARC_DEP_DONE: begin
                arc_op_q <= ARC_ENABLE;
                state_q  <= S_ARC_INIT;
              end
              ARC_ENABLE: state_q <= S_LIST;
              ARC_DEMAND: begin
                trim_q  <= 1'b0;
                state_q <= S_COV_INIT;
              end
              ARC_TRIM: state_q <= S_TRIM_POP;
              ARC_SUB: begin
                if (sts_i.mode) begin
                  state_q <= S_TIMERS;
                end else begin
                  arc_op_q <= ARC_DEP_FIRE;
                  state_q  <= S_ARC_INIT;
                end
              end
              ARC_DEP_FIRE: state_q <= S_OUT_STEP;
              default:      state_q <= S_IDLE;
            endcase
          end
        end
        S_LIST: state_q <= S_LIST_CHK;
        S_LIST_CHK: begin
          kind_q   <= KIND_NONE;
          arc_op_q <= sts_i.n_le1 ? ARC_SUB : ARC_DEMAND;
          state_q  <= S_ARC_INIT;
        end
        S_COV_INIT: state_q <= S_COV_RUN;
        S_COV_RUN: begin
          if (sts_i.cov_last) begin
            state_q <= S_COV_CHK;
          end
        end
        S_COV_CHK: begin
          state_q <= S_ARC_INIT;
          priority if (sts_i.covered) begin
            arc_op_q <= ARC_SUB;
          end else if (!trim_q && sts_i.n_eq2) begin
            kind_q   <= KIND_CHOICE;
            arc_op_q <= ARC_SUB;
          end else if (!trim_q) begin
            kind_q   <= KIND_TRIM;
            trim_q   <= 1'b1;
            arc_op_q <= ARC_TRIM;
          end else if (sts_i.m_gt1) begin
            arc_op_q <= ARC_TRIM;
          end else begin
            arc_op_q <= ARC_SUB;
          end
        end
        S_TRIM_POP: state_q <= S_COV_INIT;
        S_TIMERS:   state_q <= S_OUT_STEP;
        S_OUT_STEP: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        S_OUT_READ: begin
          if (sts_i.out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pnse_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step datapath
// Arc weight memories, marking, timers, demand sums, transition sets,
// configuration registers and the output register.
// ----------------------------------------------------------------------------
module pnse_dp #(
  parameter int MAX_PLACES      = 16,
  parameter int MAX_TRANSITIONS = 16,
  parameter int TOKEN_BITS      = 16,
  parameter int WEIGHT_BITS     = 8,
  parameter int DELAY_BITS      = 8
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pnse_pkg::cmd_t cmd_i,
  output pnse_pkg::sts_t sts_o,
  input  logic [2:0]     op_i,
  input  logic [3:0]     pi_i,
  input  logic [3:0]     ti_i,
  input  logic [15:0]    wv_i,
  input  logic           choice_i,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_index_i,
  input  logic [4:0]     cfg_data_i,
  input  logic           out_ready_i,
  output logic           out_valid_o,
  output logic           out_kind_o,
  output logic [15:0]    out_mask_o,
  output logic [4:0]     out_count_o,
  output logic [1:0]     out_conflict_o,
  output logic [15:0]    out_read_o,
  output logic           out_sat_o
);
  import pnse_pkg::*;

  localparam int P_W   = $clog2(MAX_PLACES);
  localparam int T_W   = $clog2(MAX_TRANSITIONS);
  localparam int PC_W  = $clog2(MAX_PLACES + 1);
  localparam int TC_W  = $clog2(MAX_TRANSITIONS + 1);
  localparam int N_W   = $clog2(MAX_TRANSITIONS + 1);
  localparam int DEPTH = MAX_PLACES * MAX_TRANSITIONS;
  localparam int A_W   = $clog2(DEPTH);
  localparam int DEM_W = WEIGHT_BITS + T_W;
  localparam int CMP_W = ((TOKEN_BITS > DEM_W) ? TOKEN_BITS : DEM_W) + 1;
  localparam int PC_RST = (MAX_PLACES < 16) ? MAX_PLACES : 16;
  localparam int TC_RST = (MAX_TRANSITIONS < 16) ? MAX_TRANSITIONS : 16;
  localparam logic [TOKEN_BITS-1:0] TMAX = {TOKEN_BITS{1'b1}};

  logic [TOKEN_BITS-1:0]      mark_q  [MAX_PLACES];
  logic [DEM_W-1:0]           dem_q   [MAX_PLACES];
  logic [DELAY_BITS-1:0]      rt_q    [MAX_TRANSITIONS];
  logic [DELAY_BITS-1:0]      delay_q [MAX_TRANSITIONS];
  logic [MAX_TRANSITIONS-1:0] en_q, list_q, chosen_q, done_q;
  logic                       mode_q, sat_q, cov_ok_q, choice_q;
  logic [PC_W-1:0]            pc_q;
  logic [TC_W-1:0]            tc_q;
  logic [P_W-1:0]             p_q;
  logic [T_W-1:0]             t_q;
  logic [15:0]                read_q;

  logic                       pi_ok, ti_ok, t_last, p_last, sel;
  logic [P_W-1:0]             pi_idx, mrd_idx;
  logic [T_W-1:0]             ti_idx;
  logic [A_W-1:0]             waddr, raddr;
  logic [WEIGHT_BITS-1:0]     iw_rd, ow_rd;
  logic [TOKEN_BITS-1:0]      mark_cur, wv_sat;
  logic [CMP_W-1:0]           mark_ext, iw_ext, dem_ext, dep_sum;
  logic [MAX_TRANSITIONS-1:0] list_nx, tc_mask, hi_chosen, hi_list, lo_list;
  logic [N_W-1:0]             n_cnt, m_cnt;
  logic [15:0]                rd_clip;

  assign pi_ok   = 32'(pi_i) < MAX_PLACES;
  assign ti_ok   = 32'(ti_i) < MAX_TRANSITIONS;
  assign pi_idx  = P_W'(pi_i);
  assign ti_idx  = T_W'(ti_i);
  assign mrd_idx = cmd_i.idle ? pi_idx : p_q;
  assign waddr   = A_W'(A_W'(pi_idx) * A_W'(MAX_TRANSITIONS) + A_W'(ti_idx));
  assign raddr   = A_W'(A_W'(p_q) * A_W'(MAX_TRANSITIONS) + A_W'(t_q));

  pnse_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_iw_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && op_i == OP_WR_IW && pi_ok && ti_ok),
    .waddr_i (waddr),
    .wdata_i (wv_i[WEIGHT_BITS-1:0]),
    .raddr_i (raddr),
    .rdata_o (iw_rd)
  );

  pnse_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DEPTH)) u_ow_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.accept && op_i == OP_WR_OW && pi_ok && ti_ok),
    .waddr_i (waddr),
    .wdata_i (wv_i[WEIGHT_BITS-1:0]),
    .raddr_i (raddr),
    .rdata_o (ow_rd)
  );

  assign mark_cur = mark_q[mrd_idx];
  assign mark_ext = CMP_W'(mark_cur);
  assign iw_ext   = CMP_W'(iw_rd);
  assign dem_ext  = CMP_W'(dem_q[p_q]);
  assign dep_sum  = mark_ext + CMP_W'(ow_rd);
  assign wv_sat   = (33'(wv_i) > 33'(TMAX)) ? TMAX : TOKEN_BITS'(wv_i);
  assign rd_clip  = !pi_ok ? 16'd0 :
                    (33'(mark_cur) > 33'd65535) ? 16'hFFFF : 16'(mark_cur);

  assign t_last = (TC_W'(t_q) == tc_q - TC_W'(1));
  assign p_last = (PC_W'(p_q) == pc_q - PC_W'(1));

  always_comb begin
    unique case (cmd_i.arc_op)
      ARC_DEP_DONE: sel = done_q[t_q];
      ARC_ENABLE:   sel = 1'b1;
      ARC_DEMAND:   sel = list_q[t_q];
      ARC_TRIM:     sel = hi_chosen[t_q];
      ARC_SUB:      sel = chosen_q[t_q];
      ARC_DEP_FIRE: sel = chosen_q[t_q];
      default:      sel = 1'b0;
    endcase
  end

  // Set masks, counts and the highest and lowest members of the sets.
  always_comb begin
    n_cnt     = '0;
    m_cnt     = '0;
    hi_chosen = '0;
    hi_list   = '0;
    lo_list   = '0;
    for (int i = 0; i < MAX_TRANSITIONS; i++) begin
      tc_mask[i] = (i < int'(tc_q));
      list_nx[i] = en_q[i] && (!mode_q || rt_q[i] == '0);
      n_cnt      = n_cnt + N_W'(list_q[i]);
      m_cnt      = m_cnt + N_W'(chosen_q[i]);
      if (chosen_q[i]) hi_chosen = MAX_TRANSITIONS'(1) << i;
      if (list_q[i])   hi_list   = MAX_TRANSITIONS'(1) << i;
    end
    for (int i = MAX_TRANSITIONS - 1; i >= 0; i--) begin
      if (list_q[i]) lo_list = MAX_TRANSITIONS'(1) << i;
    end
  end

  always_comb begin
    sts_o           = '0;
    sts_o.mode      = mode_q;
    sts_o.walk_last = p_last && t_last;
    sts_o.cov_last  = p_last;
    sts_o.covered   = cov_ok_q;
    sts_o.n_le1     = (n_cnt <= N_W'(1));
    sts_o.n_eq2     = (n_cnt == N_W'(2));
    sts_o.m_gt1     = (m_cnt > N_W'(1));
    sts_o.out_free  = !out_valid_o || out_ready_i;
  end

  // Control state, marking and timers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_PLACES; i++) mark_q[i] <= '0;
      for (int i = 0; i < MAX_TRANSITIONS; i++) rt_q[i] <= '0;
      en_q        <= '0;
      mode_q      <= 1'b0;
      pc_q        <= PC_W'(PC_RST);
      tc_q        <= TC_W'(TC_RST);
      sat_q       <= 1'b0;
      cov_ok_q    <= 1'b0;
      p_q         <= '0;
      t_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_MODE) begin
          mode_q <= cfg_data_i[0];
        end else if (cfg_index_i == CFG_PLACES) begin
          pc_q <= (cfg_data_i == 5'd0) ? PC_W'(1) :
                  (32'(cfg_data_i) > MAX_PLACES) ? PC_W'(MAX_PLACES) : PC_W'(cfg_data_i);
        end else if (cfg_index_i == CFG_TRANS) begin
          tc_q <= (cfg_data_i == 5'd0) ? TC_W'(1) :
                  (32'(cfg_data_i) > MAX_TRANSITIONS) ? TC_W'(MAX_TRANSITIONS) :
                  TC_W'(cfg_data_i);
        end
      end
      if (cmd_i.accept && op_i == OP_WR_MARK && pi_ok) begin
        mark_q[pi_idx] <= wv_sat;
      end
      if (cmd_i.step_init) begin
        sat_q <= 1'b0;
      end
      if (cmd_i.tick) begin
        for (int i = 0; i < MAX_TRANSITIONS; i++) begin
          if (tc_mask[i] && rt_q[i] != '0) rt_q[i] <= rt_q[i] - DELAY_BITS'(1);
        end
      end
      if (cmd_i.walk_clr) begin
        p_q <= '0;
        t_q <= '0;
        if (cmd_i.arc_op == ARC_ENABLE) en_q <= tc_mask;
      end
      if (cmd_i.arc_apply) begin
        if (t_last) begin
          t_q <= '0;
          p_q <= p_q + P_W'(1);
        end else begin
          t_q <= t_q + T_W'(1);
        end
        if (sel) begin
          if (cmd_i.arc_op == ARC_ENABLE && mark_ext < iw_ext) begin
            en_q[t_q] <= 1'b0;
          end else if (cmd_i.arc_op == ARC_SUB) begin
            mark_q[p_q] <= TOKEN_BITS'(mark_ext - iw_ext);
          end else if (cmd_i.arc_op == ARC_DEP_DONE || cmd_i.arc_op == ARC_DEP_FIRE) begin
            if (dep_sum > CMP_W'(TMAX)) begin
              mark_q[p_q] <= TMAX;
              sat_q       <= 1'b1;
            end else begin
              mark_q[p_q] <= TOKEN_BITS'(dep_sum);
            end
          end
        end
      end
      if (cmd_i.cov_clr) begin
        p_q      <= '0;
        cov_ok_q <= 1'b1;
      end
      if (cmd_i.cov_apply) begin
        p_q <= p_q + P_W'(1);
        if (mark_ext < dem_ext) cov_ok_q <= 1'b0;
      end
      if (cmd_i.load_timers) begin
        for (int i = 0; i < MAX_TRANSITIONS; i++) begin
          if (chosen_q[i]) rt_q[i] <= delay_q[i];
        end
      end
      if (cmd_i.out_step || cmd_i.out_read) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      choice_q <= choice_i;
      if (op_i == OP_WR_DELAY && ti_ok) delay_q[ti_idx] <= wv_i[DELAY_BITS-1:0];
      if (op_i == OP_READ) read_q <= rd_clip;
    end
    if (cmd_i.tick) begin
      for (int i = 0; i < MAX_TRANSITIONS; i++) begin
        done_q[i] <= tc_mask[i] && (rt_q[i] == DELAY_BITS'(1));
      end
    end
    if (cmd_i.walk_clr && cmd_i.arc_op == ARC_DEMAND) begin
      for (int i = 0; i < MAX_PLACES; i++) dem_q[i] <= '0;
    end
    if (cmd_i.arc_apply && sel) begin
      if (cmd_i.arc_op == ARC_DEMAND) begin
        dem_q[p_q] <= DEM_W'(dem_ext + iw_ext);
      end else if (cmd_i.arc_op == ARC_TRIM) begin
        dem_q[p_q] <= DEM_W'(dem_ext - iw_ext);
      end
    end
    if (cmd_i.make_list) begin
      list_q   <= list_nx;
      chosen_q <= list_nx;
    end
    if (cmd_i.pick_two) begin
      chosen_q <= choice_q ? hi_list : lo_list;
    end
    if (cmd_i.trim_pop) begin
      chosen_q <= chosen_q & ~hi_chosen;
    end
    if (cmd_i.out_step) begin
      out_kind_o     <= RES_STEP;
      out_mask_o     <= 16'(chosen_q);
      out_count_o    <= 5'(m_cnt);
      out_conflict_o <= cmd_i.kind;
      out_read_o     <= 16'd0;
      out_sat_o      <= sat_q;
    end else if (cmd_i.out_read) begin
      out_kind_o     <= RES_READ;
      out_mask_o     <= 16'd0;
      out_count_o    <= 5'd0;
      out_conflict_o <= KIND_NONE;
      out_read_o     <= read_q;
      out_sat_o      <= 1'b0;
    end
  end

endmodule

FILE: hw/rtl/petri_net_step_engine_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Petri-net step engine
// Loads arc weights, delays and marking, reads the marking back and runs
// untimed or timed firing steps of a place/transition net.
// ----------------------------------------------------------------------------
// Writes are applied on acceptance; a marking read is sampled on acceptance and raises
// m_axis_tvalid once the output register is free. A step walks the P x T weight memory
// arc by arc: 3 walks untimed or 3 timed, plus 1 demand walk and a cover check over the
// places when more than one transition is enabled, and one more walk and cover check
// per trimmed one. One item is worked on at a time; the output register lets the next
// item in. Reset clears marking, timers and output valid and resets the configuration;
// the weight and delay stores are undefined until written.
module petri_net_step_engine_unit #(
  parameter int MAX_PLACES      = 16,
  parameter int MAX_TRANSITIONS = 16,
  parameter int TOKEN_BITS      = 16,
  parameter int WEIGHT_BITS     = 8,
  parameter int DELAY_BITS      = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // place_index, transition_index, write_value, choice
  input  logic [31:0] s_axis_tdata,
  // operation
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // fired_mask, fired_count, conflict_kind, read_value, saturated
  output logic [39:0] m_axis_tdata,
  // result_kind
  output logic [0:0]  m_axis_tuser,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i
);
  import pnse_pkg::*;

  cmd_t        cmd;
  sts_t        sts;
  logic        out_kind, out_sat;
  logic [15:0] out_mask, out_read;
  logic [4:0]  out_count;
  logic [1:0]  out_conflict;

  pnse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .op_i       (s_axis_tuser),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pnse_dp #(
    .MAX_PLACES      (MAX_PLACES),
    .MAX_TRANSITIONS (MAX_TRANSITIONS),
    .TOKEN_BITS      (TOKEN_BITS),
    .WEIGHT_BITS     (WEIGHT_BITS),
    .DELAY_BITS      (DELAY_BITS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (s_axis_tuser),
    .pi_i           (s_axis_tdata[3:0]),
    .ti_i           (s_axis_tdata[7:4]),
    .wv_i           (s_axis_tdata[23:8]),
    .choice_i       (s_axis_tdata[24]),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_kind_o     (out_kind),
    .out_mask_o     (out_mask),
    .out_count_o    (out_count),
    .out_conflict_o (out_conflict),
    .out_read_o     (out_read),
    .out_sat_o      (out_sat)
  );

  assign m_axis_tdata = {out_sat, out_read, out_conflict, out_count, out_mask};
  assign m_axis_tuser = out_kind;

endmodule

FILE: sim/pnse_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Petri-net step engine checker
// Watches the configuration port and both stream channels, keeps its own
// copy of the net, predicts each step report and marking read, and compares
// every result transaction field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pnse_checker
  import pnse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [31:0] s_tdata_i,
  input  logic [2:0]  s_tuser_i,
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,
  input  logic [0:0]  m_tuser_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [4:0]  cfg_data_i,
  output int          err_count_o,
  output int          pending_o
);

  localparam int NP = 16;
  localparam int NT = 16;
  localparam int TOKEN_MAX = 65535;

  typedef struct packed {
    logic        kind;
    logic [15:0] mask;
    logic [4:0]  count;
    logic [1:0]  conflict;
    logic [15:0] rdval;
    logic        sat;
  } net_result_t;

  logic [7:0] in_wt [NP][NT];
  logic [7:0] out_wt [NP][NT];
  logic [7:0] delay_q [NT];
  int         tokens [NP];
  int         timer_q [NT];
  logic       timed;
  int         n_places;
  int         n_trans;

  net_result_t result_q[$];
  int          errors;

  assign err_count_o = errors;
  assign pending_o   = result_q.size();

  function automatic int clamp_count(logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return int'(v);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t mismatch in %s: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  function automatic bit marking_covers(input int need[NP]);
    for (int p = 0; p < n_places; p++)
      if (tokens[p] < need[p]) return 0;
    return 1;
  endfunction

  task automatic deposit_tokens(input int p, input int n, inout logic sat);
    int s;
    s = tokens[p] + n;
    if (s > TOKEN_MAX) begin
      s   = TOKEN_MAX;
      sat = 1'b1;
    end
    tokens[p] = s;
  endtask

  task automatic predict_step(input logic pick, output net_result_t r);
    int   cand[NT];
    int   need[NP];
    int   n, m, t;
    bit   ok;
    logic finished [NT];
    logic sat;
    logic [1:0] ck;
    sat = 1'b0;
    n = 0;
    ck = KIND_NONE;
    r = '0;
    r.kind = RES_STEP;
    if (timed) begin
      for (t = 0; t < n_trans; t++) begin
        finished[t] = (timer_q[t] == 1);
        if (timer_q[t] > 0) timer_q[t]--;
      end
      for (t = 0; t < n_trans; t++)
        if (finished[t])
          for (int p = 0; p < n_places; p++) deposit_tokens(p, out_wt[p][t], sat);
    end
    for (t = 0; t < n_trans; t++) begin
      ok = 1;
      for (int p = 0; p < n_places; p++)
        if (tokens[p] < in_wt[p][t]) ok = 0;
      if (ok && (!timed || timer_q[t] == 0)) begin
        cand[n] = t;
        n++;
      end
    end
    m = n;
    for (int p = 0; p < n_places; p++) begin
      need[p] = 0;
      for (int i = 0; i < n; i++) need[p] += in_wt[p][cand[i]];
    end
    if (n > 1 && !marking_covers(need)) begin
      if (n == 2) begin
        cand[0] = cand[pick];
        m = 1;
        ck = KIND_CHOICE;
      end else begin
        ck = KIND_TRIM;
        // Drop the highest-numbered transitions until the marking suffices or one is left.
        while (m > 1) begin
          for (int p = 0; p < n_places; p++) need[p] -= in_wt[p][cand[m-1]];
          m--;
          if (marking_covers(need)) break;
        end
      end
    end
    for (int i = 0; i < m; i++) begin
      t = cand[i];
      r.mask[t] = 1'b1;
      for (int p = 0; p < n_places; p++) tokens[p] -= in_wt[p][t];
      if (timed) timer_q[t] = delay_q[t];
    end
    if (!timed)
      for (int i = 0; i < m; i++)
        for (int p = 0; p < n_places; p++) deposit_tokens(p, out_wt[p][cand[i]], sat);
    r.count    = 5'(m);
    r.conflict = ck;
    r.sat      = sat;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    net_result_t r, want;
    logic [3:0]  pidx, tidx;
    logic [15:0] val;
    if (!rst_ni) begin
      timed    <= 1'b0;
      n_places <= 16;
      n_trans  <= 16;
      errors   <= 0;
      result_q.delete();
      for (int p = 0; p < NP; p++) begin
        tokens[p] <= 0;
        for (int t = 0; t < NT; t++) begin
          in_wt[p][t]  <= '0;
          out_wt[p][t] <= '0;
        end
      end
      for (int t = 0; t < NT; t++) begin
        timer_q[t] <= 0;
        delay_q[t] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_MODE:   timed = cfg_data_i[0];
          CFG_PLACES: n_places = clamp_count(cfg_data_i);
          CFG_TRANS:  n_trans = clamp_count(cfg_data_i);
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        pidx = s_tdata_i[3:0];
        tidx = s_tdata_i[7:4];
        val  = s_tdata_i[23:8];
        case (s_tuser_i)
          OP_WR_IW:    in_wt[pidx][tidx] = val[7:0];
          OP_WR_OW:    out_wt[pidx][tidx] = val[7:0];
          OP_WR_DELAY: delay_q[tidx] = val[7:0];
          OP_WR_MARK:  tokens[pidx] = int'(val);
          OP_READ: begin
            r = '0;
            r.kind  = RES_READ;
            r.rdval = 16'(tokens[pidx]);
            result_q.push_back(r);
          end
          OP_STEP: begin
            predict_step(s_tdata_i[24], r);
            result_q.push_back(r);
          end
          default: ;
        endcase
      end
      if (m_tvalid_i && m_tready_i) begin
        if (result_q.size() == 0) begin
          report_mismatch("unexpected result transactions", 1, 0);
        end else begin
          want = result_q.pop_front();
          if (m_tuser_i[0] !== want.kind) report_mismatch("result_kind", m_tuser_i, want.kind);
          if (m_tdata_i[15:0] !== want.mask)
            report_mismatch("fired_mask", m_tdata_i[15:0], want.mask);
          if (m_tdata_i[20:16] !== want.count)
            report_mismatch("fired_count", m_tdata_i[20:16], want.count);
          if (m_tdata_i[22:21] !== want.conflict)
            report_mismatch("conflict_kind", m_tdata_i[22:21], want.conflict);
          if (m_tdata_i[38:23] !== want.rdval)
            report_mismatch("read_value", m_tdata_i[38:23], want.rdval);
          if (m_tdata_i[39] !== want.sat) report_mismatch("saturated", m_tdata_i[39], want.sat);
        end
      end
    end
  end

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Petri-net step engine testbench
// Loads a full net, runs directed steps for conflicts, trimming, saturation
// and timed firing, then random phases under several configurations and
// handshake idling patterns, with a checker predicting every result.
// ----------------------------------------------------------------------------
module tb_top;
  import pnse_pkg::*;

  localparam int WATCHDOG_LIMIT = 300000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [2:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic [0:0]  m_axis_tuser;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = '0;
  logic [4:0]  cfg_data_i = '0;

  int err_count, pending;
  int tx_idle, rx_idle;
  int items_sent, idle_cycles;

  always #5 clk_i = ~clk_i;

  petri_net_step_engine_unit i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_we_i, .cfg_index_i, .cfg_data_i
  );

  pnse_checker i_checker (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid), .s_tready_i(s_axis_tready),
    .s_tdata_i(s_axis_tdata), .s_tuser_i(s_axis_tuser),
    .m_tvalid_i(m_axis_tvalid), .m_tready_i(m_axis_tready),
    .m_tdata_i(m_axis_tdata), .m_tuser_i(m_axis_tuser),
    .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .err_count_o(err_count), .pending_o(pending)
  );

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rx_idle);

  // Count cycles in which neither channel completes a transaction; stop at the watchdog limit.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [2:0] op, input logic [3:0] p, input logic [3:0] t,
                           input logic [15:0] v, input logic pick);
    while ($urandom_range(99) < tx_idle) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {7'd0, pick, v, t, p};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  // Stop sending, let every expected result arrive, then let trailing writes settle.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [4:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic random_item;
    int          sel;
    logic [15:0] v;
    sel = $urandom_range(99);
    if (sel < 35) begin
      send_item(OP_STEP, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
    end else if (sel < 55) begin
      case ($urandom_range(9))
        0: v = 16'hFFFF;
        1: v = 16'($urandom);
        2: v = 16'hFFFF - 16'($urandom_range(3));
        default: v = 16'($urandom_range(6));
      endcase
      send_item(OP_WR_MARK, 4'($urandom), 4'($urandom), v, 1'($urandom));
    end else if (sel < 80) begin
      v = ($urandom_range(7) == 0) ? 16'($urandom) : 16'($urandom_range(3));
      send_item(($urandom_range(1) == 0) ? OP_WR_IW : OP_WR_OW,
                4'($urandom), 4'($urandom), v, 1'($urandom));
    end else if (sel < 85) begin
      v = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(4));
      send_item(OP_WR_DELAY, 4'($urandom), 4'($urandom), v, 1'($urandom));
    end else if (sel < 95) begin
      send_item(OP_READ, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
    end else begin
      send_item(3'($urandom_range(7, 6)), 4'($urandom), 4'($urandom), 16'($urandom),
                1'($urandom));
    end
  endtask

  initial begin
    int cnt;
    tx_idle = 0;
    rx_idle = 0;
    items_sent = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every weight and delay gets a defined value before any step reads it.
    for (int p = 0; p < 16; p++)
      for (int t = 0; t < 16; t++) begin
        send_item(OP_WR_IW, 4'(p), 4'(t), 16'($urandom_range(2)), 1'b0);
        send_item(OP_WR_OW, 4'(p), 4'(t), 16'($urandom_range(2)), 1'b0);
      end
    for (int t = 0; t < 16; t++) send_item(OP_WR_DELAY, 4'd0, 4'(t), 16'($urandom_range(4)), 1'b0);

    // Directed: trimming, saturation, reads, ignored codes.
    drain();
    write_cfg(CFG_MODE, 5'd0);
    write_cfg(CFG_PLACES, 5'd2);
    write_cfg(CFG_TRANS, 5'd3);
    send_item(OP_WR_IW, 4'd0, 4'd0, 16'd1, 1'b0);
    send_item(OP_WR_IW, 4'd0, 4'd1, 16'd1, 1'b0);
    send_item(OP_WR_IW, 4'd0, 4'd2, 16'hFF00, 1'b0);
    send_item(OP_WR_IW, 4'd1, 4'd0, 16'd0, 1'b0);
    send_item(OP_WR_IW, 4'd1, 4'd1, 16'd0, 1'b0);
    send_item(OP_WR_IW, 4'd1, 4'd2, 16'd0, 1'b0);
    send_item(OP_WR_MARK, 4'd0, 4'd0, 16'd1, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_WR_MARK, 4'd0, 4'd0, 16'd1, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 16'd0, 1'b1);
    send_item(OP_WR_IW, 4'd0, 4'd2, 16'd1, 1'b0);
    send_item(OP_WR_MARK, 4'd0, 4'd0, 16'd2, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_WR_MARK, 4'd0, 4'd0, 16'd9, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_WR_OW, 4'd0, 4'd0, 16'hFFFF, 1'b0);
    send_item(OP_WR_MARK, 4'd0, 4'd0, 16'hFFFF, 1'b0);
    send_item(OP_STEP, 4'd0, 4'd0, 16'd0, 1'b1);
    send_item(OP_READ, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_WR_MARK, 4'd15, 4'd15, 16'hFFFF, 1'b1);
    send_item(OP_READ, 4'd15, 4'd15, 16'hFFFF, 1'b1);
    send_item(3'd6, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(3'd7, 4'd15, 4'd15, 16'hFFFF, 1'b1);

    // Directed timed run, including a transition whose delay is zero.
    drain();
    write_cfg(CFG_MODE, 5'd1);
    send_item(OP_WR_DELAY, 4'd0, 4'd0, 16'd0, 1'b0);
    send_item(OP_WR_DELAY, 4'd0, 4'd1, 16'h0102, 1'b0);
    send_item(OP_WR_MARK, 4'd0, 4'd0, 16'd3, 1'b0);
    repeat (4) send_item(OP_STEP, 4'd0, 4'd0, 16'd0, 1'b0);

    // Random phases: extremes of the counts in phases 0, 5 and 6, random settings in the others.
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      tx_idle = (ph < 2) ? 8 : (ph < 4) ? 72 : 0;
      rx_idle = (ph < 2) ? 72 : (ph < 4) ? 8 : 0;
      write_cfg(CFG_MODE, 5'($urandom_range(1)));
      case (ph)
        0: begin write_cfg(CFG_PLACES, 5'd0); write_cfg(CFG_TRANS, 5'd31); end
        5: begin write_cfg(CFG_PLACES, 5'd16); write_cfg(CFG_TRANS, 5'd16); end
        6: begin write_cfg(CFG_PLACES, 5'd31); write_cfg(CFG_TRANS, 5'd0); end
        default: begin
          write_cfg(CFG_PLACES, 5'($urandom_range(2, 6)));
          write_cfg(CFG_TRANS, 5'($urandom_range(2, 6)));
        end
      endcase
      cnt = (ph == 5 || ph == 0) ? 70 : 150;
      for (int i = 0; i < cnt; i++) begin
        if (ph == 1 && i == cnt / 2) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
          while (pending != 0) @(posedge clk_i);
        end
        random_item();
      end
    end

    drain();
    $display("Sent %0d items over directed untimed, timed and eight random phases,",
             items_sent);
    $display("covering conflicts, trimming, saturation and both idling patterns.");
    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: petri_net_step_engine_unit.f
hw/rtl/pnse_pkg.sv
hw/rtl/pnse_ram.sv
hw/rtl/pnse_ctrl.sv
hw/rtl/pnse_dp.sv
hw/rtl/petri_net_step_engine_unit.sv
sim/pnse_checker.sv
sim/tb_top.sv
